// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TUN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define TUN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and constants of the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int LANES = 3;

    typedef logic [LANES-1:0] t_lane_flags;

endpackage

// File: src/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit normal of a triangle from the exact cross product of its edges,
// scaled by the integer length and rounded to nearest.
// ----------------------------------------------------------------------------
// One input word carries the nine vertex coordinates (P2 is the pivot); it is
// taken when i_valid and o_ready are both high. One output word carries the
// three normal components and the degenerate flag; it is taken when o_valid
// and i_ready are both high.
// The pipeline has six front stages (edges, products, cross product, squares,
// sum), one stage per root bit of the square root, one stage per quotient bit
// of the divider, and the output register.
// Throughput is one word per cycle; every stage has its own valid bit, so a
// stalled receiver only holds the words behind it and bubbles still close up
// while the output waits.
// Reset empties the pipeline; nothing else is kept from word to word.
// A zero cross product gives zero components with degenerate set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_unit_normal import tun_pkg::*; #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_norm_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_norm_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_norm_z,
    output logic                                o_degenerate
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int AW  = CW + 1;
    localparam int PRW = 2 * AW;
    localparam int NW  = 2 * CW + 1;
    localparam int HL  = (NW + 1) / 2;
    localparam int HH  = NW - HL;
    localparam int SQW = 2 * NW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW / 2;
    localparam int QW  = F + 1;
    localparam int OW  = F + 2;
    localparam int SBW = 1 + LANES + LANES * NW;
    localparam int DBW = 1 + LANES;
    localparam logic signed [OW-1:0] NLIM = OW'(1) << F;

    // ---------------- front stages
    logic [5:0] r_v;
    logic [5:0] w_en;
    logic       w_sq_ready;

    logic [LANES-1:0][AW-1:0]       r0_a, r0_b, n0_a, n0_b;
    logic signed [PRW-1:0]          n1_p [LANES];
    logic signed [PRW-1:0]          n1_q [LANES];
    logic signed [PRW-1:0]          r1_p [LANES];
    logic signed [PRW-1:0]          r1_q [LANES];
    logic signed [PRW:0]            n2_n [LANES];
    logic [LANES-1:0][NW-1:0]       n2_m, r2_m, r3_m, r4_m, r5_m;
    t_lane_flags                    n2_s, r2_s, r3_s, r4_s, r5_s;
    logic [LANES-1:0][2*HH-1:0]     r3_hh;
    logic [LANES-1:0][HH+HL-1:0]    r3_hl;
    logic [LANES-1:0][2*HL-1:0]     r3_ll;
    logic [LANES-1:0][SQW-1:0]      r4_sq;
    logic [SW-1:0]                  r5_sum, n5_sum;
    logic                           r5_deg;

    always_comb begin
        n0_a[0] = {i_p1_x[CW-1], i_p1_x} - {i_p2_x[CW-1], i_p2_x};
        n0_a[1] = {i_p1_y[CW-1], i_p1_y} - {i_p2_y[CW-1], i_p2_y};
        n0_a[2] = {i_p1_z[CW-1], i_p1_z} - {i_p2_z[CW-1], i_p2_z};
        n0_b[0] = {i_p3_x[CW-1], i_p3_x} - {i_p2_x[CW-1], i_p2_x};
        n0_b[1] = {i_p3_y[CW-1], i_p3_y} - {i_p2_y[CW-1], i_p2_y};
        n0_b[2] = {i_p3_z[CW-1], i_p3_z} - {i_p2_z[CW-1], i_p2_z};
    end

    always_comb begin
        n1_p[0] = $signed(r0_a[1]) * $signed(r0_b[2]);
        n1_q[0] = $signed(r0_b[1]) * $signed(r0_a[2]);
        n1_p[1] = $signed(r0_b[0]) * $signed(r0_a[2]);
        n1_q[1] = $signed(r0_a[0]) * $signed(r0_b[2]);
        n1_p[2] = $signed(r0_a[0]) * $signed(r0_b[1]);
        n1_q[2] = $signed(r0_b[0]) * $signed(r0_a[1]);
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n2_n[l] = {r1_p[l][PRW-1], r1_p[l]} - {r1_q[l][PRW-1], r1_q[l]};
            n2_s[l] = n2_n[l][PRW];
            n2_m[l] = n2_s[l] ? NW'(-n2_n[l]) : NW'(n2_n[l]);
        end
    end

    assign n5_sum = SW'(r4_sq[0]) + SW'(r4_sq[1]) + SW'(r4_sq[2]);

    assign w_en[5] = !r_v[5] || w_sq_ready;
    assign w_en[4] = !r_v[4] || w_en[5];
    assign w_en[3] = !r_v[3] || w_en[4];
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
            if (w_en[5]) r_v[5] <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_a <= n0_a;
            r0_b <= n0_b;
        end
        if (w_en[1]) begin
            r1_p <= n1_p;
            r1_q <= n1_q;
        end
        if (w_en[2]) begin
            r2_m <= n2_m;
            r2_s <= n2_s;
        end
        if (w_en[3]) begin
            for (int l = 0; l < LANES; l++) begin
                r3_hh[l] <= r2_m[l][NW-1:HL] * r2_m[l][NW-1:HL];
                r3_hl[l] <= r2_m[l][NW-1:HL] * r2_m[l][HL-1:0];
                r3_ll[l] <= r2_m[l][HL-1:0] * r2_m[l][HL-1:0];
            end
            r3_m <= r2_m;
            r3_s <= r2_s;
        end
        if (w_en[4]) begin
            for (int l = 0; l < LANES; l++) begin
                r4_sq[l] <= (SQW'(r3_hh[l]) << (2 * HL)) + (SQW'(r3_hl[l]) << (HL + 1))
                            + SQW'(r3_ll[l]);
            end
            r4_m <= r3_m;
            r4_s <= r3_s;
        end
        if (w_en[5]) begin
            r5_sum <= n5_sum;
            r5_deg <= (n5_sum == '0);
            r5_m   <= r4_m;
            r5_s   <= r4_s;
        end
    end

    // ---------------- length and division
    logic                     w_sq_valid, w_dv_ready;
    logic [RW-1:0]            w_sq_root;
    logic [SBW-1:0]           w_sq_side;
    logic                     w_sq_deg;
    t_lane_flags              w_sq_s;
    logic [LANES-1:0][NW-1:0] w_sq_m;

    tun_isqrt #(
        .RW  (RW),
        .SBW (SBW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[5]),
        .o_ready (w_sq_ready),
        .i_sum   (r5_sum),
        .i_side  ({r5_deg, r5_s, r5_m}),
        .o_valid (w_sq_valid),
        .i_ready (w_dv_ready),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign {w_sq_deg, w_sq_s, w_sq_m} = w_sq_side;

    logic                     w_dv_valid;
    logic [LANES-1:0][QW-1:0] w_dv_quo;
    logic [DBW-1:0]           w_dv_side;
    logic                     w_dv_deg;
    t_lane_flags              w_dv_s;
    logic                     w_eno;

    tun_div #(
        .RW  (RW),
        .MW  (NW),
        .QW  (QW),
        .SBW (DBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_dv_ready),
        .i_len   (w_sq_root),
        .i_mag   (w_sq_m),
        .i_side  ({w_sq_deg, w_sq_s}),
        .o_valid (w_dv_valid),
        .i_ready (w_eno),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    assign {w_dv_deg, w_dv_s} = w_dv_side;

    // ---------------- output word
    logic                     r_vo;
    logic                     r_deg;
    logic [LANES-1:0][OW-1:0] r_norm, n_norm;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_dv_deg) begin
                n_norm[l] = '0;
            end else if (w_dv_s[l]) begin
                n_norm[l] = -OW'(w_dv_quo[l]);
            end else begin
                n_norm[l] = OW'(w_dv_quo[l]);
            end
        end
    end

    assign w_eno = !r_vo || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_eno) begin
            r_vo <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eno) begin
            r_norm <= n_norm;
            r_deg  <= w_dv_deg;
        end
    end

    assign o_valid      = r_vo;
    assign o_norm_x     = r_norm[0];
    assign o_norm_y     = r_norm[1];
    assign o_norm_z     = r_norm[2];
    assign o_degenerate = r_deg;

    `TUN_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `TUN_ASSERT(a_degenerate_zero, i_clk, i_rst_n, o_valid && o_degenerate |-> o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0, "degenerate word with nonzero normal")
    `TUN_ASSERT(a_nondegenerate_nonzero, i_clk, i_rst_n, o_valid && !o_degenerate |-> o_norm_x != '0 || o_norm_y != '0 || o_norm_z != '0, "zero normal without degenerate flag")
    `TUN_ASSERT(a_unit_range, i_clk, i_rst_n, o_valid |-> o_norm_x <= NLIM && o_norm_x >= -NLIM && o_norm_y <= NLIM && o_norm_y >= -NLIM && o_norm_z <= NLIM && o_norm_z >= -NLIM, "normal component beyond one")

endmodule

// File: src/tun_isqrt.sv
// ----------------------------------------------------------------------------
// tun_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// word that travels alongside.
// ----------------------------------------------------------------------------
module tun_isqrt #(
    parameter int RW  = 34,
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2*RW-1:0]  i_sum,
    input  logic [SBW-1:0]   i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RW-1:0]    o_root,
    output logic [SBW-1:0]   o_side
);

    localparam int SW = 2 * RW;

    logic [RW-1:0]  r_v;
    logic [RW-1:0]  w_en;
    logic [SW-1:0]  r_rem  [RW-1];
    logic [RW-1:0]  r_root [RW];
    logic [SBW-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [SW-1:0]  w_rin;
        logic [RW-1:0]  w_rtin;
        logic [SBW-1:0] w_sin;
        logic           w_vin;
        logic [SW-1:0]  w_d;
        logic           w_ge;
        logic           w_nxt;

        if (k == 0) begin : g_first
            assign w_rin  = i_sum;
            assign w_rtin = '0;
            assign w_sin  = i_side;
            assign w_vin  = i_valid;
        end else begin : g_rest
            assign w_rin  = r_rem[k-1];
            assign w_rtin = r_root[k-1];
            assign w_sin  = r_side[k-1];
            assign w_vin  = r_v[k-1];
        end

        if (k == RW - 1) begin : g_last
            assign w_nxt = i_ready;
        end else begin : g_mid
            assign w_nxt = w_en[k+1];
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_rem[k] <= w_ge ? (w_rin - w_d) : w_rin;
                end
            end
        end

        assign w_d     = (SW'(w_rtin) << (B + 1)) | (SW'(1) << (2 * B));
        assign w_ge    = (w_rin >= w_d);
        assign w_en[k] = !r_v[k] || w_nxt;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_root[k] <= w_ge ? (w_rtin | (RW'(1) << B)) : w_rtin;
                r_side[k] <= w_sin;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: src/tun_div.sv
// ----------------------------------------------------------------------------
// tun_div
// Pipelined rounding divider for the three normal components, one quotient
// bit per stage: q = floor((m * 2^QW + len) / (2 * len)).
// ----------------------------------------------------------------------------
module tun_div import tun_pkg::*; #(
    parameter int RW  = 34,
    parameter int MW  = 33,
    parameter int QW  = 15,
    parameter int SBW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [RW-1:0]               i_len,
    input  logic [LANES-1:0][MW-1:0]    i_mag,
    input  logic [SBW-1:0]              i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [LANES-1:0][QW-1:0]    o_quo,
    output logic [SBW-1:0]              o_side
);

    localparam int DW = RW + 1 + QW;

    logic [QW-1:0]                   r_v;
    logic [QW-1:0]                   w_en;
    logic [LANES-1:0][DW-1:0]        r_rem  [QW-1];
    logic [RW:0]                     r_den  [QW-1];
    logic [LANES-1:0][QW-1:0]        r_quo  [QW];
    logic [SBW-1:0]                  r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [LANES-1:0][DW-1:0] w_rin;
        logic [LANES-1:0][DW-1:0] w_rout;
        logic [LANES-1:0][QW-1:0] w_qin;
        logic [LANES-1:0][QW-1:0] w_qout;
        logic [RW:0]              w_den;
        logic [DW-1:0]            w_dsh;
        logic [SBW-1:0]           w_sin;
        logic                     w_vin;
        logic                     w_nxt;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rin[l] = (DW'(i_mag[l]) << QW) + DW'(i_len);
                end
            end
            assign w_qin = '0;
            assign w_den = {i_len, 1'b0};
            assign w_sin = i_side;
            assign w_vin = i_valid;
        end else begin : g_rest
            assign w_rin = r_rem[k-1];
            assign w_qin = r_quo[k-1];
            assign w_den = r_den[k-1];
            assign w_sin = r_side[k-1];
            assign w_vin = r_v[k-1];
        end

        assign w_dsh = DW'(w_den) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (w_rin[l] >= w_dsh) begin
                    w_rout[l] = w_rin[l] - w_dsh;
                    w_qout[l] = w_qin[l] | (QW'(1) << B);
                end else begin
                    w_rout[l] = w_rin[l];
                    w_qout[l] = w_qin[l];
                end
            end
        end

        if (k == QW - 1) begin : g_last
            assign w_nxt = i_ready;
        end else begin : g_mid
            assign w_nxt = w_en[k+1];
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_rem[k] <= w_rout;
                    r_den[k] <= w_den;
                end
            end
        end

        assign w_en[k] = !r_v[k] || w_nxt;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_quo[k]  <= w_qout;
                r_side[k] <= w_sin;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: bench/tb_triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Self-checking bench for the triangle unit normal block: a directed table of
// triangles followed by random ones, each output word compared against the
// table's value or an exact cross-product, square-root and rounding predictor.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;
    import tun_pkg::*;

    localparam int CW       = 16;
    localparam int FB       = 14;
    localparam int OW       = FB + 2;
    localparam int N_RANDOM = 750;
    localparam int IDLE_MAX = 2000;
    localparam int DRAIN    = 70;

    typedef struct packed {
        logic signed [OW-1:0] nx;
        logic signed [OW-1:0] ny;
        logic signed [OW-1:0] nz;
        logic                 deg;
    } normal_t;

    typedef struct {
        logic signed [CW-1:0] c [9];
        bit                   typed;
        normal_t              want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CW-1:0] vtx [9];
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OW-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic o_degenerate;

    bit      row_typed = 1'b0;
    normal_t row_want = '0;
    normal_t expected_normals [$];
    int      n_fail = 0;
    int      n_in = 0;
    int      n_out = 0;
    int      n_degen = 0;
    int      idle_cycles = 0;

    initial for (int k = 0; k < 9; k++) vtx[k] = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    triangle_unit_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_p1_x(vtx[0]), .i_p1_y(vtx[1]), .i_p1_z(vtx[2]),
        .i_p2_x(vtx[3]), .i_p2_y(vtx[4]), .i_p2_z(vtx[5]),
        .i_p3_x(vtx[6]), .i_p3_y(vtx[7]), .i_p3_z(vtx[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_degenerate(o_degenerate)
    );

    function automatic normal_t unit_normal(logic signed [CW-1:0] c [9]);
        longint        a [3], b [3], n [3];
        logic [79:0]   mag [3];
        logic [79:0]   sum, root, trial;
        logic [127:0]  num, q;
        logic [OW-1:0] comp [3];
        normal_t       r;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(c[i]) - longint'(c[3+i]);
            b[i] = longint'(c[6+i]) - longint'(c[3+i]);
        end
        n[0] = a[1] * b[2] - b[1] * a[2];
        n[1] = b[0] * a[2] - a[0] * b[2];
        n[2] = a[0] * b[1] - b[0] * a[1];
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (n[i] < 0) ? 80'(-n[i]) : 80'(n[i]);
            sum += mag[i] * mag[i];
        end
        r = '0;
        if (sum == 0) begin
            r.deg = 1'b1;
            return r;
        end
        root = '0;
        for (int i = 39; i >= 0; i--) begin
            trial = root | (80'd1 << i);
            if (trial * trial <= sum) root = trial;
        end
        for (int i = 0; i < 3; i++) begin
            num = (128'(mag[i]) << (FB + 1)) + 128'(root);
            q = num / (128'(root) << 1);
            comp[i] = (n[i] < 0) ? OW'(-q) : OW'(q);
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        return r;
    endfunction

    // input side: record the expectation of every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_normals.push_back(row_typed ? row_want : unit_normal(vtx));
            n_in++;
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_valid && i_ready) begin
            n_out++;
            if (o_degenerate) n_degen++;
            if (expected_normals.size() == 0) begin
                $error("output word with no expectation pending");
                n_fail++;
            end else begin
                want = expected_normals.pop_front();
                if (o_norm_x !== want.nx) begin
                    $error("norm_x expected %0d got %0d", want.nx, o_norm_x);
                    n_fail++;
                end
                if (o_norm_y !== want.ny) begin
                    $error("norm_y expected %0d got %0d", want.ny, o_norm_y);
                    n_fail++;
                end
                if (o_norm_z !== want.nz) begin
                    $error("norm_z expected %0d got %0d", want.nz, o_norm_z);
                    n_fail++;
                end
                if (o_degenerate !== want.deg) begin
                    $error("degenerate expected %0d got %0d", want.deg, o_degenerate);
                    n_fail++;
                end
            end
        end
    end

    // receiver with random stalls
    initial begin
        int w;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = $urandom_range(0, 4);
            if (w > 0) begin
                i_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_valid && i_ready)) @(posedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("watchdog: no progress for %0d cycles", IDLE_MAX);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(row_t r);
        int w;
        w = $urandom_range(0, 4);
        if (w > 0) begin
            i_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        for (int k = 0; k < 9; k++) vtx[k] <= r.c[k];
        row_typed <= r.typed;
        row_want <= r.want;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!(i_valid && o_ready)) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
    endtask

    function automatic row_t mk(int p1x, int p1y, int p1z, int p2x, int p2y, int p2z,
                                int p3x, int p3y, int p3z, bit typed = 0,
                                int ex = 0, int ey = 0, int ez = 0, bit ed = 0);
        row_t r;
        r.c[0] = CW'(p1x); r.c[1] = CW'(p1y); r.c[2] = CW'(p1z);
        r.c[3] = CW'(p2x); r.c[4] = CW'(p2y); r.c[5] = CW'(p2z);
        r.c[6] = CW'(p3x); r.c[7] = CW'(p3y); r.c[8] = CW'(p3z);
        r.typed = typed;
        r.want.nx = OW'(ex); r.want.ny = OW'(ey); r.want.nz = OW'(ez);
        r.want.deg = ed;
        return r;
    endfunction

    function automatic row_t rand_row(int mode);
        row_t r;
        int   k;
        r.typed = 0;
        r.want = '0;
        for (int i = 0; i < 9; i++) begin
            if (mode == 0) r.c[i] = CW'($urandom);
            else r.c[i] = CW'($urandom_range(0, 64) - 32);
        end
        if (mode == 2) begin
            // collinear: p3 on the line through p2 and p1
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) r.c[6+i] = CW'(r.c[3+i] + k * (r.c[i] - r.c[3+i]));
        end
        return r;
    endfunction

    initial begin
        row_t dir [$];
        int   mode;
        dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        dir.push_back(mk(256, 0, 0, 0, 0, 0, 0, 256, 0, 1, 0, 0, 16384, 0));
        dir.push_back(mk(0, 256, 0, 0, 0, 0, 256, 0, 0, 1, 0, 0, -16384, 0));
        dir.push_back(mk(0, 256, 0, 0, 0, 0, 0, 0, 256, 1, 16384, 0, 0, 0));
        dir.push_back(mk(0, 0, 256, 0, 0, 0, 256, 0, 0, 1, 0, 16384, 0, 0));
        dir.push_back(mk(0, 0, 256, 0, 0, 0, 0, 256, 0, 1, -16384, 0, 0, 0));
        dir.push_back(mk(5, 5, 5, 5, 5, 5, 5, 5, 5, 1, 0, 0, 0, 1));
        dir.push_back(mk(2, 4, 6, 1, 2, 3, 3, 6, 9, 1, 0, 0, 0, 1));
        dir.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                         32767, -32768, 32767));
        dir.push_back(mk(32767, -32768, -32768, -32768, 32767, -32768,
                         -32768, -32768, 32767));
        dir.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                         -32768, 32767, -32768));
        dir.push_back(mk(32767, 0, 0, -32768, 0, 0, -32768, 32767, 0));
        dir.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(1, 1, 0, 0, 0, 0, 0, 1, 1));
        dir.push_back(mk(3, 0, 0, 0, 0, 0, 0, 1, 1));
        dir.push_back(mk(-1, -1, -1, 0, 0, 0, 1, -1, 0));
        dir.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                         -32768, -32768, -32768, 1, 0, 0, 0, 1));
        dir.push_back(mk(100, 7, -3, -20, 11, 9, 40, -60, 2));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i]) send_word(dir[i]);
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) wait_drained();
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 0 : (mode < 9) ? 1 : 2;
            send_word(rand_row(mode));
        end
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);

        $display("triangles sent %0d, normals checked %0d, degenerate %0d",
                 n_in, n_out, n_degen);
        $display("directed axes, extremes and collinear cases plus random triangles");
        if (n_fail == 0 && expected_normals.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/tun_pkg.sv
src/tun_isqrt.sv
src/tun_div.sv
src/triangle_unit_normal.sv
bench/tb_triangle_unit_normal.sv
